// ===== sv/bsw_pkg.sv =====
// Shared types, constants and header byte table of the BMP stream writer.
package bsw_pkg;

    localparam int DIM_BITS_DEF = 14;
    localparam int CFG_ADDR_W   = 4;
    localparam int HDR_LEN      = 54;
    localparam int INFO_LEN     = 40;

    localparam logic [7:0] MAGIC_B  = 8'h42;
    localparam logic [7:0] MAGIC_M  = 8'h4D;
    localparam logic [5:0] HDR_LAST = 6'(HDR_LEN - 1);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BPP    = 2'd2
    } bsw_reg_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_HDR,
        PH_PIX,
        PH_PAD
    } bsw_phase_t;

    // per-item control passed from front to back
    typedef struct packed {
        logic       hdr;
        logic [1:0] pad;
        logic       fend;
        logic [7:0] pix;
    } bsw_ctl_t;

    function automatic logic [7:0] hdr_byte(
        input logic [5:0]  idx,
        input logic [31:0] size,
        input logic [31:0] w,
        input logic [31:0] h,
        input logic [2:0]  bpp
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0:    b = MAGIC_B;
            6'd1:    b = MAGIC_M;
            6'd2:    b = size[7:0];
            6'd3:    b = size[15:8];
            6'd4:    b = size[23:16];
            6'd5:    b = size[31:24];
            6'd10:   b = 8'(HDR_LEN);
            6'd14:   b = 8'(INFO_LEN);
            6'd18:   b = w[7:0];
            6'd19:   b = w[15:8];
            6'd20:   b = w[23:16];
            6'd21:   b = w[31:24];
            6'd22:   b = h[7:0];
            6'd23:   b = h[15:8];
            6'd24:   b = h[23:16];
            6'd25:   b = h[31:24];
            6'd26:   b = 8'd1;
            6'd28:   b = {2'b00, bpp, 3'b000};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/bsw_if.sv =====
// Stream interfaces: pixel byte input and file byte output.
interface bsw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bsw_file_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       last_of_run;
    logic       frame_done;

    modport source (output valid, output file_byte, output last_of_run,
                    output frame_done, input ready);
    modport sink   (input valid, input file_byte, input last_of_run,
                    input frame_done, output ready);
endinterface

// ===== sv/bmp_stream_writer_top.sv =====
// BMP stream writer top level: APB registers, front end, queue and back end.
// Pixel bytes go in, BMP file bytes come out at up to one byte per cycle.
// An input transfer that only passes a pixel byte yields one output byte; the
// first transfer of a frame yields 55 bytes (54 header bytes plus the pixel),
// and a row's last byte adds up to 3 pad bytes. The output byte rate is set by
// the back end, which emits one byte per cycle, unless the output is stalled,
// into a one-stage output register; a two-entry queue lets the front end
// take one more transfer while the back end works through a header or
// padding, after which input stalls until that entry is done. Program width,
// height and bytes per pixel only while the stream is idle.
module bmp_stream_writer_top #(
    parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    bsw_pix_if.sink                        pix_in,
    bsw_file_if.source                     file_out
);
    import bsw_pkg::*;

    localparam int DIM_W = 3 * DIM_BITS + 5;
    localparam int CTL_W = $bits(bsw_ctl_t);
    localparam int Q_W   = CTL_W + DIM_W;

    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;
    logic [2:0]          bytes_per_pixel;

    logic                push_valid;
    logic                push_ready;
    bsw_ctl_t            push_ctl;
    logic [DIM_W-1:0]    push_dim;
    logic                pop_valid;
    logic                pop_ready;
    bsw_ctl_t            pop_ctl;
    logic [DIM_W-1:0]    pop_dim;
    logic [Q_W-1:0]      pop_data;

    bsw_cfg #(
        .DIM_BITS (DIM_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .image_width     (image_width),
        .image_height    (image_height),
        .bytes_per_pixel (bytes_per_pixel)
    );

    bsw_front #(
        .DIM_BITS (DIM_BITS),
        .DIM_W    (DIM_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix             (pix_in),
        .image_width     (image_width),
        .image_height    (image_height),
        .bytes_per_pixel (bytes_per_pixel),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_ctl        (push_ctl),
        .push_dim        (push_dim)
    );

    bsw_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctl, push_dim}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_ctl = bsw_ctl_t'(pop_data[Q_W-1:DIM_W]);
    assign pop_dim = pop_data[DIM_W-1:0];

    bsw_back #(
        .DIM_BITS (DIM_BITS),
        .DIM_W    (DIM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_ctl   (pop_ctl),
        .pop_dim   (pop_dim),
        .file      (file_out)
    );

endmodule

// ===== sv/bsw_cfg.sv =====
// APB configuration registers: image width, height and bytes per pixel.
module bsw_cfg #(
    parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [DIM_BITS-1:0]           image_width,
    output logic [DIM_BITS-1:0]           image_height,
    output logic [2:0]                    bytes_per_pixel
);
    import bsw_pkg::*;

    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [2:0]          bpp_reg;
    logic                wr_en;
    bsw_reg_t            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = bsw_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
            bpp_reg    <= 3'd3;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                REG_BPP:    bpp_reg    <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_BPP:    prdata = 32'(bpp_reg);
            default:    prdata = 32'd0;
        endcase
    end

    assign image_width     = width_reg;
    assign image_height    = height_reg;
    assign bytes_per_pixel = bpp_reg;

endmodule

// ===== sv/bsw_front.sv =====
// Front end: accepts pixel bytes, tracks row/frame position, classifies each transfer.
module bsw_front #(
    parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEF,
    parameter int DIM_W    = 3 * DIM_BITS + 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bsw_pix_if.sink              pix,
    input  logic [DIM_BITS-1:0]  image_width,
    input  logic [DIM_BITS-1:0]  image_height,
    input  logic [2:0]           bytes_per_pixel,
    output logic                 push_valid,
    input  logic                 push_ready,
    output bsw_pkg::bsw_ctl_t    push_ctl,
    output logic [DIM_W-1:0]     push_dim
);
    import bsw_pkg::*;

    localparam int RL_W = DIM_BITS + 2;

    logic                hdr_done_reg;
    logic                hdr_done_next;
    logic [RL_W-1:0]     rbc_reg;
    logic [RL_W-1:0]     rbc_next;
    logic [DIM_BITS-1:0] rc_reg;
    logic [DIM_BITS-1:0] rc_next;

    logic [DIM_BITS-1:0] eff_w;
    logic [DIM_BITS-1:0] eff_h;
    logic [2:0]          eff_b;
    logic [RL_W:0]       prod_full;
    logic [RL_W-1:0]     row_len;
    logic [RL_W-1:0]     pad_sum;
    logic [RL_W-1:0]     padded;
    logic [RL_W-1:0]     cnt_inc;
    logic [DIM_BITS:0]   rows_inc;
    logic                row_end;
    logic                frame_end;
    logic                accept;

    assign eff_w = (image_width == '0) ? DIM_BITS'(1) : image_width;
    assign eff_h = (image_height == '0) ? DIM_BITS'(1) : image_height;

    always_comb
    begin
        if (bytes_per_pixel == 3'd0)
            eff_b = 3'd1;
        else if (bytes_per_pixel > 3'd4)
            eff_b = 3'd4;
        else
            eff_b = bytes_per_pixel;
    end

    assign prod_full = (RL_W + 1)'(eff_w) * (RL_W + 1)'(eff_b);
    assign row_len   = prod_full[RL_W-1:0];
    assign pad_sum   = row_len + RL_W'(3);
    assign padded    = {pad_sum[RL_W-1:2], 2'b00};

    assign cnt_inc   = rbc_reg + RL_W'(1);
    assign rows_inc  = {1'b0, rc_reg} + (DIM_BITS + 1)'(1);
    assign row_end   = (cnt_inc >= row_len);
    assign frame_end = row_end && (rows_inc >= {1'b0, eff_h});

    assign accept     = pix.valid && push_ready;
    assign pix.ready  = push_ready;
    assign push_valid = pix.valid;

    always_comb
    begin
        push_ctl.hdr  = !hdr_done_reg;
        push_ctl.pad  = row_end ? (2'b00 - row_len[1:0]) : 2'b00;
        push_ctl.fend = frame_end;
        push_ctl.pix  = pix.pixel_byte;
    end

    assign push_dim = {eff_w, eff_h, eff_b, padded};

    always_comb
    begin
        hdr_done_next = hdr_done_reg;
        rbc_next      = rbc_reg;
        rc_next       = rc_reg;
        if (accept)
        begin
            hdr_done_next = !frame_end;
            rbc_next      = row_end ? '0 : cnt_inc;
            if (frame_end)
                rc_next = '0;
            else if (row_end)
                rc_next = rows_inc[DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_done_reg <= 1'b0;
            rbc_reg      <= '0;
            rc_reg       <= '0;
        end
        else
        begin
            hdr_done_reg <= hdr_done_next;
            rbc_reg      <= rbc_next;
            rc_reg       <= rc_next;
        end
    end

endmodule

// ===== sv/bsw_queue.sv =====
// Two-entry queue between front end and back end.
module bsw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/bsw_back.sv =====
// Back end: expands each queued entry into header, pixel and pad bytes.
module bsw_back #(
    parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEF,
    parameter int DIM_W    = 3 * DIM_BITS + 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  bsw_pkg::bsw_ctl_t pop_ctl,
    input  logic [DIM_W-1:0]  pop_dim,
    bsw_file_if.source        file
);
    import bsw_pkg::*;

    localparam int RL_W   = DIM_BITS + 2;
    localparam int PROD_W = RL_W + DIM_BITS;

    logic [DIM_BITS-1:0] hd_w;
    logic [DIM_BITS-1:0] hd_h;
    logic [2:0]          hd_b;
    logic [RL_W-1:0]     hd_padded;

    bsw_phase_t          phase_reg;
    bsw_phase_t          phase_next;
    logic [5:0]          idx_reg;
    logic [5:0]          idx_next;
    logic [1:0]          pad_left_reg;
    logic [1:0]          pad_left_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [31:0]         size_reg;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;
    logic                out_fdone_reg;

    logic                advance;
    logic [7:0]          emit_byte;
    logic                emit_last;

    assign {hd_w, hd_h, hd_b, hd_padded} = pop_dim;

    assign advance   = pop_valid && (!out_valid_reg || file.ready);
    assign pop_ready = advance && emit_last;

    // file size pipeline through prod_reg and size_reg; settles before the header's size bytes are emitted
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(hd_padded) * PROD_W'(hd_h);
        size_reg <= 32'(prod_reg) + 32'(HDR_LEN);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        pad_left_next = pad_left_reg;
        emit_byte     = pop_ctl.pix;
        emit_last     = 1'b0;
        case (phase_reg)
            PH_HEAD:
            begin
                if (pop_ctl.hdr)
                begin
                    emit_byte  = hdr_byte(6'd0, size_reg, 32'(hd_w), 32'(hd_h), hd_b);
                    phase_next = PH_HDR;
                    idx_next   = 6'd1;
                end
                else if (pop_ctl.pad == 2'd0)
                begin
                    emit_last = 1'b1;
                end
                else
                begin
                    phase_next    = PH_PAD;
                    pad_left_next = pop_ctl.pad;
                end
            end
            PH_HDR:
            begin
                emit_byte = hdr_byte(idx_reg, size_reg, 32'(hd_w), 32'(hd_h), hd_b);
                idx_next  = idx_reg + 6'd1;
                if (idx_reg == HDR_LAST)
                    phase_next = PH_PIX;
            end
            PH_PIX:
            begin
                if (pop_ctl.pad == 2'd0)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_HEAD;
                end
                else
                begin
                    phase_next    = PH_PAD;
                    pad_left_next = pop_ctl.pad;
                end
            end
            PH_PAD:
            begin
                emit_byte     = 8'h00;
                pad_left_next = pad_left_reg - 2'd1;
                if (pad_left_reg == 2'd1)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_HEAD;
                end
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            idx_reg       <= '0;
            pad_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                pad_left_reg  <= pad_left_next;
                out_valid_reg <= 1'b1;
            end
            else if (file.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= emit_byte;
            out_last_reg  <= emit_last;
            out_fdone_reg <= emit_last && pop_ctl.fend;
        end
    end

    assign file.valid       = out_valid_reg;
    assign file.file_byte   = out_byte_reg;
    assign file.last_of_run = out_last_reg;
    assign file.frame_done  = out_fdone_reg;

endmodule
